/* rtl/dedc_pkg.sv */
`default_nettype none

package dedc_pkg;

    // defaults for the top level parameters
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int HIST_DEPTH_DEF   = 256;
    localparam int COUNT_BITS_DEF   = 32;

    // field widths
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 16;
    localparam int BASE_W   = 3;
    localparam int QUERY_W  = 8;
    localparam int OUT_W    = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 5 * OUT_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAXLEN_W   = 8;
    localparam int WIN_W      = 6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_LEN     = 2'd0,
        CFG_MAX_LEN     = 2'd1,
        CFG_WINDOW_SIZE = 2'd2
    } cfg_index_t;

    localparam logic [LEN_W-1:0]    MIN_LEN_RST     = 16'd0;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RST     = 8'd255;
    localparam logic [WIN_W-1:0]    WINDOW_SIZE_RST = 6'd25;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ_START = 2'd0,
        KIND_BASE       = 2'd1,
        KIND_SKIP       = 2'd2,
        KIND_READOUT    = 2'd3
    } kind_t;

    // base codes
    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    localparam logic [LEN_W-1:0] POS_MAX = 16'hFFFF;

endpackage

`default_nettype wire

/* rtl/dna_end_damage_counter_top.sv */
`default_nettype none

// a readout item's result goes through stage 1 and the output register to m_axis
// throughput: one item per cycle while no readout in stage 1 waits on a full output
// register; each counter memory does one read-modify-write per cycle, with the last
// write bypassed into the next read; reset: aresetn is synchronous and active low;
// afterwards a clearing pass zeroes every counter while s_axis_tready is low
module dna_end_damage_counter_top #(
    parameter int WINDOW_DEPTH = dedc_pkg::WINDOW_DEPTH_DEF,
    parameter int HIST_DEPTH   = dedc_pkg::HIST_DEPTH_DEF,
    parameter int COUNT_BITS   = dedc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [dedc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [dedc_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // input items
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // read_length[15:0], excluded[16], reference base code[19:17],
    // read base code[22:20], skip_count[38:23], query_index[46:39], zero pad[47]
    input  wire logic [dedc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[1:0]
    input  wire logic [dedc_pkg::KIND_W-1:0]       s_axis_tuser,

    // readout results
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // c_to_t_count[31:0], c_total_count[63:32], g_to_a_count[95:64],
    // g_total_count[127:96], length_bin_count[159:128]
    output      logic [dedc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int WA  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int HA  = $clog2(HIST_DEPTH);
    localparam int CLR_DEPTH = (WINDOW_DEPTH > HIST_DEPTH) ? WINDOW_DEPTH : HIST_DEPTH;
    localparam int CW  = $clog2(CLR_DEPTH);
    localparam int LW  = dedc_pkg::LEN_W;
    localparam int OW  = dedc_pkg::OUT_W;
    localparam logic [LW-1:0] WIN_DEPTH_L  = LW'(WINDOW_DEPTH);
    localparam logic [LW-1:0] HIST_DEPTH_L = LW'(HIST_DEPTH);
    localparam logic [CW-1:0] CLR_LAST     = CW'(CLR_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    // ---------------------------------------------------------------
    // input field unpacking
    // ---------------------------------------------------------------
    dedc_pkg::kind_t               in_kind;
    logic [LW-1:0]                 in_len;
    logic                          in_excl;
    logic [dedc_pkg::BASE_W-1:0]   in_ref;
    logic [dedc_pkg::BASE_W-1:0]   in_rd;
    logic [LW-1:0]                 in_skip;
    logic [dedc_pkg::QUERY_W-1:0]  in_q;

    assign in_kind = dedc_pkg::kind_t'(s_axis_tuser);
    assign in_len  = s_axis_tdata[15:0];
    assign in_excl = s_axis_tdata[16];
    assign in_ref  = s_axis_tdata[19:17];
    assign in_rd   = s_axis_tdata[22:20];
    assign in_skip = s_axis_tdata[38:23];
    assign in_q    = s_axis_tdata[46:39];

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [LW-1:0]                   min_len_reg;
    logic [dedc_pkg::MAXLEN_W-1:0]   max_len_reg;
    logic [dedc_pkg::WIN_W-1:0]      window_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg     <= dedc_pkg::MIN_LEN_RST;
            max_len_reg     <= dedc_pkg::MAX_LEN_RST;
            window_size_reg <= dedc_pkg::WINDOW_SIZE_RST;
        end else if (cfg_we) begin
            case (dedc_pkg::cfg_index_t'(cfg_addr))
                dedc_pkg::CFG_MIN_LEN:     min_len_reg     <= cfg_wdata;
                dedc_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg_wdata[dedc_pkg::MAXLEN_W-1:0];
                dedc_pkg::CFG_WINDOW_SIZE: window_size_reg <= cfg_wdata[dedc_pkg::WIN_W-1:0];
                default: ; // index beyond the register list is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // clearing pass after reset
    // ---------------------------------------------------------------
    logic          clearing_reg;
    logic [CW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    logic clr_win_en;
    logic clr_hist_en;
    assign clr_win_en  = clearing_reg && (32'(clr_cnt_reg) < 32'(WINDOW_DEPTH));
    assign clr_hist_en = clearing_reg && (32'(clr_cnt_reg) < 32'(HIST_DEPTH));

    // ---------------------------------------------------------------
    // handshake: a readout result held in stage 1 behind a full output
    // register, or the clearing pass, stalls the input side
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_readout_reg;
    logic s1_stall;
    logic accept;

    assign s1_stall      = s1_valid_reg && s1_readout_reg && m_axis_tvalid && !m_axis_tready;
    assign s_axis_tready = !clearing_reg && !s1_stall;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // stage 0: read tracking and counter addressing
    // ---------------------------------------------------------------
    logic [LW-1:0] read_position_reg, read_position_next;
    logic [LW-1:0] current_length_reg, current_length_next;
    logic          read_active_reg, read_active_next;

    logic [LW-1:0] eff_win;
    logic [LW-1:0] from_end;
    logic [LW:0]   skip_sum;
    logic [LW-1:0] q_ext;
    logic          is_base;
    logic          is_readout;
    logic          start_ok;
    logic          hit5;
    logic          hit3;
    logic          bump_c5, bump_ct, bump_g3, bump_ga, bump_hist;
    logic [WA-1:0] addr5, addr3;
    logic [HA-1:0] addr_hist;

    always_comb begin
        eff_win    = ({10'd0, window_size_reg} < WIN_DEPTH_L) ? {10'd0, window_size_reg}
                                                              : WIN_DEPTH_L;
        from_end   = current_length_reg - read_position_reg - LW'(1);
        skip_sum   = {1'b0, read_position_reg} + {1'b0, in_skip};
        q_ext      = {8'd0, in_q};
        is_base    = (in_kind == dedc_pkg::KIND_BASE) && read_active_reg;
        is_readout = (in_kind == dedc_pkg::KIND_READOUT);
        start_ok   = !in_excl && (in_len >= min_len_reg) && (in_len <= {8'd0, max_len_reg});

        // 5' end: first positions of the read
        hit5    = is_base && (read_position_reg < eff_win) && (in_ref == dedc_pkg::BASE_C);
        bump_c5 = hit5;
        bump_ct = hit5 && (in_rd == dedc_pkg::BASE_T);

        // 3' end: distance from the last base, only inside the read
        hit3    = is_base && (read_position_reg < current_length_reg) && (from_end < eff_win)
                  && (in_ref == dedc_pkg::BASE_G);
        bump_g3 = hit3;
        bump_ga = hit3 && (in_rd == dedc_pkg::BASE_A);

        bump_hist = (in_kind == dedc_pkg::KIND_READ_START) && start_ok && (in_len < HIST_DEPTH_L);

        addr5     = is_readout ? q_ext[WA-1:0] : read_position_reg[WA-1:0];
        addr3     = is_readout ? q_ext[WA-1:0] : from_end[WA-1:0];
        addr_hist = is_readout ? q_ext[HA-1:0] : in_len[HA-1:0];

        read_position_next  = read_position_reg;
        current_length_next = current_length_reg;
        read_active_next    = read_active_reg;
        case (in_kind)
            dedc_pkg::KIND_READ_START: begin
                read_active_next = start_ok;
                if (start_ok) begin
                    current_length_next = in_len;
                    read_position_next  = '0;
                end
            end
            dedc_pkg::KIND_BASE: begin
                if (read_active_reg && (read_position_reg != dedc_pkg::POS_MAX)) begin
                    read_position_next = read_position_reg + LW'(1);
                end
            end
            dedc_pkg::KIND_SKIP: begin
                if (read_active_reg) begin
                    read_position_next = skip_sum[LW] ? dedc_pkg::POS_MAX : skip_sum[LW-1:0];
                end
            end
            default: ; // readout leaves the read state alone
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_position_reg  <= '0;
            current_length_reg <= '0;
            read_active_reg    <= 1'b0;
        end else if (accept) begin
            read_position_reg  <= read_position_next;
            current_length_reg <= current_length_next;
            read_active_reg    <= read_active_next;
        end
    end

    // stage 1 control
    logic          s1_c5_reg, s1_ct_reg, s1_g3_reg, s1_ga_reg, s1_hist_reg;
    logic          s1_win_ok_reg, s1_hist_ok_reg;
    logic [WA-1:0] s1_addr5_reg, s1_addr3_reg;
    logic [HA-1:0] s1_addr_hist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (!s1_stall) begin
            s1_valid_reg <= 1'b0;
        end
        if (accept) begin
            s1_readout_reg   <= is_readout;
            s1_c5_reg        <= bump_c5;
            s1_ct_reg        <= bump_ct;
            s1_g3_reg        <= bump_g3;
            s1_ga_reg        <= bump_ga;
            s1_hist_reg      <= bump_hist;
            s1_win_ok_reg    <= q_ext < WIN_DEPTH_L;
            s1_hist_ok_reg   <= q_ext < HIST_DEPTH_L;
            s1_addr5_reg     <= addr5;
            s1_addr3_reg     <= addr3;
            s1_addr_hist_reg <= addr_hist;
        end
    end

    // ---------------------------------------------------------------
    // counter memories and saturating updates
    // ---------------------------------------------------------------
    logic [COUNT_BITS-1:0] c5_q, ct_q, g3_q, ga_q, hist_q;
    logic [COUNT_BITS-1:0] c5_inc, ct_inc, g3_inc, ga_inc, hist_inc;
    logic                  c5_we, ct_we, g3_we, ga_we, hist_we;
    logic [WA-1:0]         w5_addr, w3_addr;
    logic [HA-1:0]         wh_addr;

    assign c5_inc   = (&c5_q)   ? c5_q   : c5_q   + CNT_ONE;
    assign ct_inc   = (&ct_q)   ? ct_q   : ct_q   + CNT_ONE;
    assign g3_inc   = (&g3_q)   ? g3_q   : g3_q   + CNT_ONE;
    assign ga_inc   = (&ga_q)   ? ga_q   : ga_q   + CNT_ONE;
    assign hist_inc = (&hist_q) ? hist_q : hist_q + CNT_ONE;

    assign c5_we   = clearing_reg ? clr_win_en  : (s1_valid_reg && s1_c5_reg);
    assign ct_we   = clearing_reg ? clr_win_en  : (s1_valid_reg && s1_ct_reg);
    assign g3_we   = clearing_reg ? clr_win_en  : (s1_valid_reg && s1_g3_reg);
    assign ga_we   = clearing_reg ? clr_win_en  : (s1_valid_reg && s1_ga_reg);
    assign hist_we = clearing_reg ? clr_hist_en : (s1_valid_reg && s1_hist_reg);

    assign w5_addr = clearing_reg ? clr_cnt_reg[WA-1:0] : s1_addr5_reg;
    assign w3_addr = clearing_reg ? clr_cnt_reg[WA-1:0] : s1_addr3_reg;
    assign wh_addr = clearing_reg ? clr_cnt_reg[HA-1:0] : s1_addr_hist_reg;

    dedc_cnt_ram #(.DEPTH(WINDOW_DEPTH), .AW(WA), .DW(COUNT_BITS)) u_c5_ram (
        .aclk, .aresetn, .rd_en(accept), .rd_addr(addr5),
        .wr_en(c5_we), .wr_addr(w5_addr), .wr_data(clearing_reg ? '0 : c5_inc),
        .rd_data(c5_q)
    );

    dedc_cnt_ram #(.DEPTH(WINDOW_DEPTH), .AW(WA), .DW(COUNT_BITS)) u_ct_ram (
        .aclk, .aresetn, .rd_en(accept), .rd_addr(addr5),
        .wr_en(ct_we), .wr_addr(w5_addr), .wr_data(clearing_reg ? '0 : ct_inc),
        .rd_data(ct_q)
    );

    dedc_cnt_ram #(.DEPTH(WINDOW_DEPTH), .AW(WA), .DW(COUNT_BITS)) u_g3_ram (
        .aclk, .aresetn, .rd_en(accept), .rd_addr(addr3),
        .wr_en(g3_we), .wr_addr(w3_addr), .wr_data(clearing_reg ? '0 : g3_inc),
        .rd_data(g3_q)
    );

    dedc_cnt_ram #(.DEPTH(WINDOW_DEPTH), .AW(WA), .DW(COUNT_BITS)) u_ga_ram (
        .aclk, .aresetn, .rd_en(accept), .rd_addr(addr3),
        .wr_en(ga_we), .wr_addr(w3_addr), .wr_data(clearing_reg ? '0 : ga_inc),
        .rd_data(ga_q)
    );

    dedc_cnt_ram #(.DEPTH(HIST_DEPTH), .AW(HA), .DW(COUNT_BITS)) u_hist_ram (
        .aclk, .aresetn, .rd_en(accept), .rd_addr(addr_hist),
        .wr_en(hist_we), .wr_addr(wh_addr), .wr_data(clearing_reg ? '0 : hist_inc),
        .rd_data(hist_q)
    );

    // ---------------------------------------------------------------
    // result register: low bits of each counter, zero beyond the stores
    // ---------------------------------------------------------------
    logic [COUNT_BITS+OW-1:0] ext_ct, ext_c5, ext_ga, ext_g3, ext_hist;
    logic [dedc_pkg::OUT_DATA_W-1:0] result;

    always_comb begin
        ext_ct   = {{OW{1'b0}}, ct_q};
        ext_c5   = {{OW{1'b0}}, c5_q};
        ext_ga   = {{OW{1'b0}}, ga_q};
        ext_g3   = {{OW{1'b0}}, g3_q};
        ext_hist = {{OW{1'b0}}, hist_q};
        result = {
            s1_hist_ok_reg ? ext_hist[OW-1:0] : {OW{1'b0}},
            s1_win_ok_reg  ? ext_g3[OW-1:0]   : {OW{1'b0}},
            s1_win_ok_reg  ? ext_ga[OW-1:0]   : {OW{1'b0}},
            s1_win_ok_reg  ? ext_c5[OW-1:0]   : {OW{1'b0}},
            s1_win_ok_reg  ? ext_ct[OW-1:0]   : {OW{1'b0}}
        };
    end

    logic load_out;
    assign load_out = s1_valid_reg && s1_readout_reg && !s1_stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (load_out) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
        if (load_out) begin
            m_axis_tdata <= result;
        end
    end

endmodule

`default_nettype wire

/* rtl/dedc_cnt_ram.sv */
`default_nettype none

// counter memory: one write port, one registered read port, and a
// bypass of the most recent write so a read issued on the same edge
// as a write still sees the new value
module dedc_cnt_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    output      logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [DW-1:0] lw_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr_en) begin
            lw_valid_reg <= 1'b1;
        end
        if (wr_en) begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : q_reg;

endmodule

`default_nettype wire

/* verif/tb_dna_end_damage_counter_top.sv */
`timescale 1ns / 1ps

module tb_dna_end_damage_counter_top;

    localparam int WINDOW_DEPTH = dedc_pkg::WINDOW_DEPTH_DEF;
    localparam int HIST_DEPTH   = dedc_pkg::HIST_DEPTH_DEF;
    localparam int COUNT_BITS   = dedc_pkg::COUNT_BITS_DEF;

    // field widths used for casts
    localparam int LW  = dedc_pkg::LEN_W;
    localparam int QW  = dedc_pkg::QUERY_W;
    localparam int BW  = dedc_pkg::BASE_W;
    localparam int OW  = dedc_pkg::OUT_W;
    localparam int CDW = dedc_pkg::CFG_DATA_W;

    // cycles with no item moving on either side before the run is called hung;
    // covers the clearing pass after reset and the long receiver hold-off
    localparam int STALL_LIMIT  = 3000;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES  = 400;

    // input item fields as packed in s_axis_tdata, lowest bit last
    typedef struct packed {
        logic                pad;
        logic [QW-1:0]       query_index;
        logic [LW-1:0]       skip_count;
        logic [BW-1:0]       read_code;
        logic [BW-1:0]       ref_code;
        logic                excluded;
        logic [LW-1:0]       read_length;
    } read_item_t;

    // readout fields as packed in m_axis_tdata, lowest field last
    typedef struct packed {
        logic [OW-1:0] length_bin_count;
        logic [OW-1:0] g_total_count;
        logic [OW-1:0] g_to_a_count;
        logic [OW-1:0] c_total_count;
        logic [OW-1:0] c_to_t_count;
    } damage_counts_t;

    // damage counter predictor plus queue of readouts still owed by the block
    class damage_scoreboard;
        logic [LW-1:0]                 min_len;
        logic [dedc_pkg::MAXLEN_W-1:0] max_len;
        logic [dedc_pkg::WIN_W-1:0]    win_size;
        int                  position;
        int                  cur_len;
        bit                  read_open;
        logic [OW-1:0]       c_total  [WINDOW_DEPTH];
        logic [OW-1:0]       c_to_t   [WINDOW_DEPTH];
        logic [OW-1:0]       g_total  [WINDOW_DEPTH];
        logic [OW-1:0]       g_to_a   [WINDOW_DEPTH];
        logic [OW-1:0]       len_hist [HIST_DEPTH];
        damage_counts_t      owed_counts[$];
        int                  errors;

        function new();
            min_len   = dedc_pkg::MIN_LEN_RST;
            max_len   = dedc_pkg::MAX_LEN_RST;
            win_size  = dedc_pkg::WINDOW_SIZE_RST;
            position  = 0;
            cur_len   = 0;
            read_open = 1'b0;
            errors    = 0;
            foreach (c_total[i]) begin
                c_total[i] = '0;
                c_to_t[i]  = '0;
                g_total[i] = '0;
                g_to_a[i]  = '0;
            end
            foreach (len_hist[i]) len_hist[i] = '0;
        endfunction

        function logic [OW-1:0] sat_inc(logic [OW-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        function void write_reg(dedc_pkg::cfg_index_t idx, logic [CDW-1:0] v);
            case (idx)
                dedc_pkg::CFG_MIN_LEN:     min_len  = v;
                dedc_pkg::CFG_MAX_LEN:     max_len  = v[dedc_pkg::MAXLEN_W-1:0];
                dedc_pkg::CFG_WINDOW_SIZE: win_size = v[dedc_pkg::WIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(dedc_pkg::kind_t kind, read_item_t it);
            int             eff_win;
            int             from_end;
            int             sum;
            damage_counts_t want;
            eff_win = (win_size < WINDOW_DEPTH) ? int'(win_size) : WINDOW_DEPTH;
            case (kind)
                dedc_pkg::KIND_READ_START: begin
                    if (it.excluded || it.read_length < min_len ||
                        it.read_length > max_len) begin
                        read_open = 1'b0;
                    end else begin
                        if (it.read_length < HIST_DEPTH)
                            len_hist[it.read_length] = sat_inc(len_hist[it.read_length]);
                        read_open = 1'b1;
                        cur_len   = int'(it.read_length);
                        position  = 0;
                    end
                end
                dedc_pkg::KIND_BASE: begin
                    if (read_open) begin
                        if (position < eff_win && it.ref_code == dedc_pkg::BASE_C) begin
                            c_total[position] = sat_inc(c_total[position]);
                            if (it.read_code == dedc_pkg::BASE_T)
                                c_to_t[position] = sat_inc(c_to_t[position]);
                        end
                        if (position < cur_len) begin
                            from_end = cur_len - position - 1;
                            if (from_end < eff_win && it.ref_code == dedc_pkg::BASE_G) begin
                                g_total[from_end] = sat_inc(g_total[from_end]);
                                if (it.read_code == dedc_pkg::BASE_A)
                                    g_to_a[from_end] = sat_inc(g_to_a[from_end]);
                            end
                        end
                        if (position < int'(dedc_pkg::POS_MAX)) position++;
                    end
                end
                dedc_pkg::KIND_SKIP: begin
                    if (read_open) begin
                        sum = position + int'(it.skip_count);
                        position = (sum > int'(dedc_pkg::POS_MAX)) ?
                                   int'(dedc_pkg::POS_MAX) : sum;
                    end
                end
                dedc_pkg::KIND_READOUT: begin
                    want = '0;
                    if (it.query_index < WINDOW_DEPTH) begin
                        want.c_to_t_count  = c_to_t[it.query_index];
                        want.c_total_count = c_total[it.query_index];
                        want.g_to_a_count  = g_to_a[it.query_index];
                        want.g_total_count = g_total[it.query_index];
                    end
                    if (it.query_index < HIST_DEPTH)
                        want.length_bin_count = len_hist[it.query_index];
                    owed_counts = {owed_counts, want};
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [OW-1:0] got, logic [OW-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(damage_counts_t got);
            damage_counts_t want;
            if (owed_counts.size() == 0) begin
                report("readout result with no readout pending");
                return;
            end
            want = owed_counts.pop_front();
            compare_field("c_to_t_count",     got.c_to_t_count,     want.c_to_t_count);
            compare_field("c_total_count",    got.c_total_count,    want.c_total_count);
            compare_field("g_to_a_count",     got.g_to_a_count,     want.g_to_a_count);
            compare_field("g_total_count",    got.g_total_count,    want.g_total_count);
            compare_field("length_bin_count", got.length_bin_count, want.length_bin_count);
        endtask

        function int pending();
            return owed_counts.size();
        endfunction
    endclass

    // clock, reset and block ports, the bench-driven ones known from time zero
    logic                                aclk;
    logic                                aresetn       = 1'b0;
    logic                                cfg_we        = 1'b0;
    logic [dedc_pkg::CFG_ADDR_W-1:0]     cfg_addr      = dedc_pkg::CFG_MIN_LEN;
    logic [CDW-1:0]                      cfg_wdata     = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [dedc_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;
    logic [dedc_pkg::KIND_W-1:0]         s_axis_tuser  = dedc_pkg::KIND_READ_START;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [dedc_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

    damage_scoreboard board = new();

    // idling percentages per side, and the hold-off request for the receiver
    int tx_idle_pct  = 20;
    int rx_idle_pct  = 61;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    dna_end_damage_counter_top #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .HIST_DEPTH   (HIST_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check at the edge, then pick tready for the next cycle
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                board.check_result(damage_counts_t'(m_axis_tdata));
            if (rx_hold_left == 0 && rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                // long hold-off, lets the pipeline back up into s_axis
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: ends the run once nothing has moved for too long
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one item, holding tvalid until the block takes it
    task automatic offer_item(dedc_pkg::kind_t kind, read_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_item(kind, it);
        items_sent++;
    endtask

    // unused fields carry random bits so every tdata bit but the pad toggles
    function automatic read_item_t rand_fields();
        read_item_t it;
        it.pad         = 1'b0;
        it.query_index = QW'($urandom_range(255));
        it.skip_count  = LW'($urandom_range(65535));
        it.read_code   = BW'($urandom_range(7));
        it.ref_code    = BW'($urandom_range(7));
        it.excluded    = 1'($urandom_range(1));
        it.read_length = LW'($urandom_range(65535));
        return it;
    endfunction

    task automatic send_start(int len, bit excl);
        read_item_t it;
        it = rand_fields();
        it.read_length = LW'(len);
        it.excluded    = excl;
        offer_item(dedc_pkg::KIND_READ_START, it);
    endtask

    task automatic send_base(logic [BW-1:0] refb, logic [BW-1:0] rdb);
        read_item_t it;
        it = rand_fields();
        it.ref_code  = refb;
        it.read_code = rdb;
        offer_item(dedc_pkg::KIND_BASE, it);
    endtask

    task automatic send_skip(int n);
        read_item_t it;
        it = rand_fields();
        it.skip_count = LW'(n);
        offer_item(dedc_pkg::KIND_SKIP, it);
    endtask

    task automatic send_readout(int q);
        read_item_t it;
        it = rand_fields();
        it.query_index = QW'(q);
        offer_item(dedc_pkg::KIND_READOUT, it);
    endtask

    // base pair with a bias toward deamination-like changes
    task automatic send_damaged_base();
        logic [BW-1:0] refb;
        logic [BW-1:0] rdb;
        refb = ($urandom_range(9) == 0) ? BW'($urandom_range(7, 4)) : BW'($urandom_range(3));
        if (refb == dedc_pkg::BASE_C && $urandom_range(99) < 40)
            rdb = dedc_pkg::BASE_T;
        else if (refb == dedc_pkg::BASE_G && $urandom_range(99) < 40)
            rdb = dedc_pkg::BASE_A;
        else if ($urandom_range(99) < 85)
            rdb = refb;
        else
            rdb = BW'($urandom_range(7));
        send_base(refb, rdb);
    endtask

    // readout index: mostly the window, sometimes a used length or anything
    function automatic int pick_query(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(33);
        if (r < 80) return $urandom_range(hi, lo) % 256;
        return $urandom_range(255);
    endfunction

    // one read: start, then bases with skips and readouts mixed in
    task automatic send_read(int lo, int hi);
        int len;
        int p;
        int r;
        int n;
        int short_hi;
        short_hi = (hi < lo + 40) ? hi : lo + 40;
        len = ($urandom_range(9) == 0) ? $urandom_range(hi, lo) : $urandom_range(short_hi, lo);
        // a few excluded reads, whose bases must be ignored
        send_start(len, ($urandom_range(99) < 5));
        p = 0;
        while (p < len) begin
            r = $urandom_range(99);
            if (len > 80 && p == 30) begin
                // jump over the middle of a long read to reach the 3' window
                send_skip(len - 70);
                p = len - 40;
            end else if (r < 6) begin
                n = $urandom_range(3, 1);
                send_skip(n);
                p += n;
            end else if (r < 14) begin
                send_readout(pick_query(lo, hi));
            end else begin
                send_damaged_base();
                p++;
            end
        end
        // sometimes a base past the read end
        if ($urandom_range(4) == 0) send_damaged_base();
    endtask

    // mostly well-formed reads, the rest random items of any kind
    task automatic run_phase(int n, int lo, int hi);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 85)
                send_read(lo, hi);
            else
                offer_item(dedc_pkg::kind_t'($urandom_range(3)), rand_fields());
        end
    endtask

    // stop offering and wait for every owed readout, then for the pipeline
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register writes, only while the block is idle
    task automatic apply_config(int min_l, int max_l, int win);
        cfg_we    <= 1'b1;
        cfg_addr  <= dedc_pkg::CFG_MIN_LEN;
        cfg_wdata <= CDW'(min_l);
        @(posedge aclk);
        board.write_reg(dedc_pkg::CFG_MIN_LEN, CDW'(min_l));
        cfg_addr  <= dedc_pkg::CFG_MAX_LEN;
        cfg_wdata <= CDW'(max_l);
        @(posedge aclk);
        board.write_reg(dedc_pkg::CFG_MAX_LEN, CDW'(max_l));
        cfg_addr  <= dedc_pkg::CFG_WINDOW_SIZE;
        cfg_wdata <= CDW'(win);
        @(posedge aclk);
        board.write_reg(dedc_pkg::CFG_WINDOW_SIZE, CDW'(win));
        cfg_we    <= 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // wait out the counter clearing pass
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);

        // directed part, reset settings written explicitly
        apply_config(0, 255, 25);
        send_base(dedc_pkg::BASE_C, dedc_pkg::BASE_T);   // no read open yet
        send_skip(5);                                    // no read open yet
        send_start(10, 1'b1);                            // excluded read
        send_base(dedc_pkg::BASE_C, dedc_pkg::BASE_T);   // ignored after rejection
        send_start(65535, 1'b0);                         // longer than the length ceiling
        send_start(255, 1'b0);                           // longest counted read
        send_base(dedc_pkg::BASE_C, dedc_pkg::BASE_T);   // 5' position 0
        send_base(dedc_pkg::BASE_G, dedc_pkg::BASE_A);   // far from the 3' window
        send_skip(65535);                                // position saturates
        send_base(dedc_pkg::BASE_G, dedc_pkg::BASE_A);   // past read end, position stays
        send_start(0, 1'b0);                             // zero-length read
        send_base(dedc_pkg::BASE_C, dedc_pkg::BASE_T);   // counts at 5' only
        send_start(3, 1'b0);
        send_base(dedc_pkg::BASE_G, dedc_pkg::BASE_A);   // 3' position 2
        send_base(BW'(7), BW'(7));                       // other codes
        send_base(dedc_pkg::BASE_G, dedc_pkg::BASE_G);   // 3' position 0, no change
        send_readout(0);
        send_readout(1);
        send_readout(2);
        send_readout(WINDOW_DEPTH - 1);
        send_readout(WINDOW_DEPTH);                      // beyond the position stores
        send_readout(255);
        wait_drain();

        // zero window and zero length ceiling
        apply_config(0, 0, 0);
        send_start(0, 1'b0);
        send_base(dedc_pkg::BASE_C, dedc_pkg::BASE_T);
        send_readout(0);
        wait_drain();

        // length floor above any countable read
        apply_config(65535, 255, 63);
        send_start(200, 1'b0);
        send_base(dedc_pkg::BASE_G, dedc_pkg::BASE_A);
        send_readout(200);
        wait_drain();

        // sender mostly busy, receiver mostly stalling, full window
        apply_config(8, 120, 32);
        run_phase(150, 8, 120);
        wait_drain();

        // roles swapped, window setting above the store depth
        tx_idle_pct = 61;
        rx_idle_pct = 20;
        apply_config(0, 255, 63);
        run_phase(150, 0, 255);
        wait_drain();

        // no idling, one-position window, plus a backed-up pipeline
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(20, 60, 1);
        run_phase(60, 20, 60);
        rx_hold_req = HOLD_CYCLES;
        repeat (40) send_readout(pick_query(20, 60));
        wait_drain();
        run_phase(70, 20, 60);
        wait_drain();

        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/dedc_pkg.sv
rtl/dedc_cnt_ram.sv
rtl/dna_end_damage_counter_top.sv
verif/tb_dna_end_damage_counter_top.sv
